// ===== src/bmpe_pkg.sv =====
`timescale 1ns / 1ps

package bmpe_pkg;

   // largest payload the encoder will fill, capacity is clamped to it
   localparam int MAX_PAYLOAD = 244;
   localparam int CAP_MIN     = 5;
   localparam int CAP_RESET   = 73;
   // one bit above the capacity register so fill plus message never wraps
   localparam int CAP_W       = $clog2(MAX_PAYLOAD + 8) + 1;

   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

   localparam int NUM_SLOTS   = 6;

   // request kinds
   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_FLUSH  = 1'b1;

   // register indexes
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   // result slots, in emission order
   localparam int SLOT_CLOSE  = 0;
   localparam int SLOT_HEADER = 1;
   localparam int SLOT_STAMP  = 2;
   localparam int SLOT_STATUS = 3;
   localparam int SLOT_DATA1  = 4;
   localparam int SLOT_DATA2  = 5;

   // running status boundaries
   localparam logic [7:0] STATUS_SYSCOM   = 8'hF0;
   localparam logic [7:0] STATUS_REALTIME = 8'hF8;
   localparam logic [7:0] STATUS_MSB      = 8'h80;

   // one message (or flush) worth of work handed from front to back
   typedef struct packed {
      logic [NUM_SLOTS-1:0] slots;
      logic [5:0]           stamp_hi;
      logic [6:0]           stamp_lo;
      logic [7:0]           status;
      logic [6:0]           data_one;
      logic [6:0]           data_two;
   } job_type;

endpackage

// ===== src/bmpe_front.sv =====
`timescale 1ns / 1ps

module bmpe_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          capacity,
   input  logic                accept,
   input  logic                req_type,
   input  logic [7:0]          status_byte,
   input  logic [6:0]          data_one,
   input  logic [6:0]          data_two,
   input  logic [1:0]          msg_len,
   input  logic [12:0]         stamp,
   output logic                push,
   output bmpe_pkg::job_type   job
);

   localparam int CW = bmpe_pkg::CAP_W;

   logic [7:0]    fill_ff, fill_in;
   logic [7:0]    rs_ff, rs_in;

   logic [CW-1:0] cap_eff;
   logic [7:0]    status_fix;
   logic [1:0]    len_fix;
   logic          open_pkt;
   logic          overflow;
   logic          start;
   logic [7:0]    rs_cur;
   logic          hit;
   logic [CW-1:0] need;
   logic [7:0]    fill_base;
   logic [bmpe_pkg::NUM_SLOTS-1:0] slots;

   always_comb begin
      if ({{(CW-8){1'b0}}, capacity} > CW'(bmpe_pkg::MAX_PAYLOAD)) begin
         cap_eff = CW'(bmpe_pkg::MAX_PAYLOAD);
      end else if (capacity < 8'(bmpe_pkg::CAP_MIN)) begin
         cap_eff = CW'(bmpe_pkg::CAP_MIN);
      end else begin
         cap_eff = {{(CW-8){1'b0}}, capacity};
      end

      status_fix = status_byte | bmpe_pkg::STATUS_MSB;
      len_fix    = (msg_len == 2'd0) ? 2'd1 : msg_len;
      open_pkt   = (fill_ff != 8'd0);

      // message plus its stamp byte must fit the room that is left
      need     = {{(CW-8){1'b0}}, fill_ff} + {{(CW-2){1'b0}}, len_fix} + CW'(1);
      overflow = open_pkt && (need > cap_eff);
      start    = !open_pkt || overflow;

      rs_cur = start ? 8'd0 : rs_ff;
      hit    = (rs_cur != 8'd0) && (status_fix == rs_cur);

      if (hit) begin
         rs_in = rs_cur;
      end else if (status_fix < bmpe_pkg::STATUS_REALTIME) begin
         rs_in = (status_fix < bmpe_pkg::STATUS_SYSCOM) ? status_fix : 8'd0;
      end else begin
         rs_in = rs_cur;
      end

      fill_base = start ? 8'd1 : fill_ff;

      slots = '0;
      if (req_type == bmpe_pkg::REQ_FLUSH) begin
         slots[bmpe_pkg::SLOT_CLOSE] = open_pkt;
         fill_in = 8'd0;
         rs_in   = rs_ff;
      end else begin
         slots[bmpe_pkg::SLOT_CLOSE]  = overflow;
         slots[bmpe_pkg::SLOT_HEADER] = start;
         slots[bmpe_pkg::SLOT_STAMP]  = 1'b1;
         slots[bmpe_pkg::SLOT_STATUS] = !hit;
         slots[bmpe_pkg::SLOT_DATA1]  = (len_fix >= 2'd2);
         slots[bmpe_pkg::SLOT_DATA2]  = (len_fix == 2'd3);
         fill_in = fill_base + 8'd1 + {6'd0, len_fix} - {7'd0, hit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 8'd0;
         rs_ff   <= 8'd0;
      end else if (accept) begin
         fill_ff <= fill_in;
         rs_ff   <= rs_in;
      end
   end

   assign push          = accept && (slots != '0);
   assign job.slots     = slots;
   assign job.stamp_hi  = stamp[12:7];
   assign job.stamp_lo  = stamp[6:0];
   assign job.status    = status_fix;
   assign job.data_one  = data_one;
   assign job.data_two  = data_two;

endmodule

// ===== src/bmpe_fifo.sv =====
`timescale 1ns / 1ps

module bmpe_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bmpe_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output bmpe_pkg::job_type head
);

   localparam int AW    = bmpe_pkg::FIFO_AW;
   localparam int DEPTH = bmpe_pkg::FIFO_DEPTH;

   bmpe_pkg::job_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [AW:0]   count_ff, count_in;

   assign full  = (count_ff == (AW+1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + AW'(1) : wr_ff;
      rd_in    = pop ? rd_ff + AW'(1) : rd_ff;
      count_in = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== src/bmpe_back.sv =====
`timescale 1ns / 1ps

module bmpe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  bmpe_pkg::job_type q_head,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_byte,
   output logic              byte_valid,
   output logic              packet_close,
   output logic              out_last
);

   localparam int NS = bmpe_pkg::NUM_SLOTS;

   bmpe_pkg::job_type cur_ff, cur_in;
   logic [NS-1:0] mask_ff, mask_in;
   logic          valid_ff, valid_in;
   logic [7:0]    byte_ff, byte_in;
   logic          bvalid_ff, bvalid_in;
   logic          close_ff, close_in;
   logic          last_ff, last_in;

   logic [NS-1:0] low;
   logic [NS-1:0] rest;
   logic          advance;

   always_comb begin
      low     = mask_ff & (~mask_ff + NS'(1));
      rest    = mask_ff & ~low;
      advance = (mask_ff != '0) && (!valid_ff || out_ready);

      cur_in    = cur_ff;
      mask_in   = mask_ff;
      valid_in  = valid_ff && !out_ready;
      byte_in   = byte_ff;
      bvalid_in = bvalid_ff;
      close_in  = close_ff;
      last_in   = last_ff;
      q_pop     = 1'b0;

      if (advance) begin
         valid_in  = 1'b1;
         close_in  = low[bmpe_pkg::SLOT_CLOSE];
         bvalid_in = !low[bmpe_pkg::SLOT_CLOSE];
         last_in   = (rest == '0);
         byte_in   = ({8{low[bmpe_pkg::SLOT_HEADER]}} & {2'b10, cur_ff.stamp_hi})
                   | ({8{low[bmpe_pkg::SLOT_STAMP]}}  & {1'b1, cur_ff.stamp_lo})
                   | ({8{low[bmpe_pkg::SLOT_STATUS]}} & cur_ff.status)
                   | ({8{low[bmpe_pkg::SLOT_DATA1]}}  & {1'b0, cur_ff.data_one})
                   | ({8{low[bmpe_pkg::SLOT_DATA2]}}  & {1'b0, cur_ff.data_two});
         mask_in   = rest;
      end

      // take the next job when the current one is done or finishing now
      if (((mask_ff == '0) || (advance && (rest == '0))) && !q_empty) begin
         q_pop   = 1'b1;
         cur_in  = q_head;
         mask_in = q_head.slots;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
      cur_ff    <= cur_in;
      byte_ff   <= byte_in;
      bvalid_ff <= bvalid_in;
      close_ff  <= close_in;
      last_ff   <= last_in;
   end

   assign out_valid    = valid_ff;
   assign out_byte     = byte_ff;
   assign byte_valid   = bvalid_ff;
   assign packet_close = close_ff;
   assign out_last     = last_ff;

endmodule

// ===== src/ble_midi_packet_encoder.sv =====
`timescale 1ns / 1ps

// midi message to packet byte stream encoder
// req channel: one transfer per complete midi message (tuser = 0) or per
//   flush request (tuser = 1); tdata carries status, data bytes, length, stamp
// rsp channel: one transfer per packet byte, or a close marker (tuser[1])
//   telling the sink that the open packet is complete; tlast marks the final
//   transfer caused by a request; a flush with no open packet yields nothing
// csr port: one register, payload_capacity at address 0 (reset 73),
//   clamped inside to 5..244; write it only while the block is idle
// path: the first result of a request passes the queue write, then the job load
//   and then the output register when the back end is idle
// throughput: the back end emits one result per cycle while rsp_tready is high,
//   and a request yields 1 to 6 results (close, header, stamp, up to 3 bytes);
//   the front takes a request per cycle while the 4-entry job queue has room
// reset: no packet open, no running status, capacity back to 73, queue empty
// stall: when rsp_tready is low the output register holds, the back end
//   stops, the job queue fills and then req_tready drops
module ble_midi_packet_encoder (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] status_byte, [14:8] data_one, [21:15] data_two, [23:22] msg_len,
   // [36:24] stamp, [39:37] zero
   input  logic [39:0] req_tdata,
   // [0] req_type
   input  logic [0:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte
   output logic [7:0]  rsp_tdata,
   // [0] byte_valid, [1] packet_close
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0] cap_ff;
   logic       csr_wr;
   logic       csr_hit;

   logic              accept;
   logic              push;
   bmpe_pkg::job_type push_job;
   logic              pop;
   logic              q_full;
   logic              q_empty;
   bmpe_pkg::job_type q_head;

   logic       byte_valid;
   logic       packet_close;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == bmpe_pkg::CSR_IDX_CAPACITY);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {24'd0, cap_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 8'(bmpe_pkg::CAP_RESET);
      end else if (csr_wr && csr_hit) begin
         cap_ff <= csr_pwdata[7:0];
      end
   end

   // front: classify, track packet fill and running status
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   bmpe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .capacity    (cap_ff),
      .accept      (accept),
      .req_type    (req_tuser[0]),
      .status_byte (req_tdata[7:0]),
      .data_one    (req_tdata[14:8]),
      .data_two    (req_tdata[21:15]),
      .msg_len     (req_tdata[23:22]),
      .stamp       (req_tdata[36:24]),
      .push        (push),
      .job         (push_job)
   );

   // job queue decoupling front and back
   bmpe_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   // back: serialize each job into result transfers
   bmpe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_byte     (rsp_tdata),
      .byte_valid   (byte_valid),
      .packet_close (packet_close),
      .out_last     (rsp_tlast)
   );

   assign rsp_tuser = {packet_close, byte_valid};

endmodule
